// File: rtl/hufd_pkg.sv
`timescale 1ns / 1ps
// shared types, sizes and helpers for the bit-serial huffman decoder
// used by every file in rtl; depends on nothing

package hufd_pkg;

	// table and code sizes
	localparam int NUM_SYMBOLS  = 256;
	localparam int MAX_CODE_LEN = 16;
	localparam int SYM_W        = 8;
	localparam int LEN_W        = 5;
	localparam int CODE_W       = 16;
	localparam int ACC_W        = MAX_CODE_LEN;
	localparam int CNT_W        = $clog2(MAX_CODE_LEN + 1);
	localparam int CMP_W        = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;

	// input word kinds
	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_DECODE = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	// table write broadcast to every cell
	typedef struct packed {
		logic              en;
		logic [SYM_W-1:0]  sym;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} load_t;

	// current accumulator contents, broadcast to every cell
	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic [CNT_W-1:0] cnt;
	} query_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic             valid;
		logic             found;
		logic [SYM_W-1:0] sym;
	} link_t;

	// ones in the low len bits
	function automatic logic [CMP_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		logic [CMP_W-1:0] m;
		for (int b = 0; b < CMP_W; b++) begin
			m[b] = (b < int'(len));
		end
		return m;
	endfunction

endpackage

// File: rtl/hufd_cell.sv
`timescale 1ns / 1ps
// one table entry of the decoder: code word, length and one stage of the search chain
// depends on hufd_pkg

module hufd_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [hufd_pkg::SYM_W-1:0] idx,
	input  hufd_pkg::load_t          load,
	input  hufd_pkg::query_t         query,
	input  hufd_pkg::link_t          link_in,
	output hufd_pkg::link_t          link_out
);

	logic [hufd_pkg::CODE_W-1:0] code_q;
	logic [hufd_pkg::LEN_W-1:0]  len_q;
	logic                        valid_q;
	logic                        found_q;
	logic [hufd_pkg::SYM_W-1:0]  sym_q;
	logic                        wr;
	logic                        hit;

	assign wr = load.en && (load.sym == idx);

	// entry is present, has the accumulated length and its low bits equal the accumulator
	assign hit = (len_q != '0) && (8'(len_q) == 8'(query.cnt)) &&
		((hufd_pkg::CMP_W'(code_q) & hufd_pkg::len_mask(len_q)) ==
		 hufd_pkg::CMP_W'(query.acc));

	// length and token control, cleared at reset so every entry starts absent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			valid_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (wr) begin
				len_q <= load.len;
			end
			valid_q <= link_in.valid;
			found_q <= link_in.found | (link_in.valid & hit);
		end
	end

	// code word and carried symbol
	always_ff @(posedge clk) begin
		if (wr) begin
			code_q <= load.code;
		end
		sym_q <= link_in.found ? link_in.sym : idx;
	end

	assign link_out = '{valid: valid_q, found: found_q, sym: sym_q};

endmodule

// File: rtl/hufd_chain.sv
`timescale 1ns / 1ps
// row of table cells; the search token walks from symbol 0 upward, one cell a cycle
// depends on hufd_pkg and hufd_cell

module hufd_chain (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  hufd_pkg::load_t  load,
	input  hufd_pkg::query_t query,
	output hufd_pkg::link_t  done
);

	hufd_pkg::link_t links [hufd_pkg::NUM_SYMBOLS+1];

	// token enters at the lowest symbol with nothing found yet
	assign links[0] = '{valid: start, found: 1'b0, sym: '0};

	// one cell per symbol
	for (genvar i = 0; i < hufd_pkg::NUM_SYMBOLS; i++) begin : g_cell
		hufd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (hufd_pkg::SYM_W'(i)),
			.load     (load),
			.query    (query),
			.link_in  (links[i]),
			.link_out (links[i+1])
		);
	end

	assign done = links[hufd_pkg::NUM_SYMBOLS];

endmodule

// File: rtl/huffman_bit_serial_decoder.sv
`timescale 1ns / 1ps
// channel  dir  tdata                                               tuser
// s_       in   [7:0] symbol, [12:8] length, [28:13] code, [29] bit  [1:0] kind
// m_       out  [7:0] decoded symbol                                 [0] overflow error
//
// load and clear words leave the input ready; a decode word keeps the input off until its
// search is done, the search token walking the row of table cells one cell per cycle
// reset marks every table entry absent at once, no clearing pass is needed
// a result waiting on m_ holds up the input only after a decode bit whose search ends in a
// symbol or an overflow error before the result is taken
// top level: controller, accumulator and output register; depends on hufd_pkg, hufd_chain

module huffman_bit_serial_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // entry_symbol, entry_length, entry_code, stream_bit, zero
	input  logic [1:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // decoded_symbol
	output logic [0:0]  m_tuser    // overflow_error
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_HOLD
	} state_t;

	state_t                      state_q;
	logic [hufd_pkg::ACC_W-1:0]  acc_q;
	logic [hufd_pkg::CNT_W-1:0]  cnt_q;
	logic                        start_q;
	logic                        m_valid_q;
	logic [hufd_pkg::SYM_W-1:0]  m_sym_q;
	logic                        m_err_q;
	logic [hufd_pkg::SYM_W-1:0]  pend_sym_q;
	logic                        pend_err_q;

	hufd_pkg::kind_t  kind;
	hufd_pkg::load_t  load;
	hufd_pkg::query_t query;
	hufd_pkg::link_t  done;
	logic             accept;
	logic             out_free;
	logic             res_err;
	logic             res_any;
	logic [hufd_pkg::SYM_W-1:0] res_sym;

	// input word unpacking
	assign kind   = hufd_pkg::kind_t'(s_tuser);
	assign accept = s_tvalid && s_tready;
	assign load   = '{
		en:   accept && (kind == hufd_pkg::KIND_LOAD),
		sym:  s_tdata[7:0],
		len:  s_tdata[12:8],
		code: s_tdata[28:13]
	};
	assign query = '{acc: acc_q, cnt: cnt_q};

	hufd_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.load   (load),
		.query  (query),
		.done   (done)
	);

	// outcome of a finished search
	assign res_err  = !done.found && (cnt_q >= hufd_pkg::CNT_W'(hufd_pkg::MAX_CODE_LEN));
	assign res_any  = done.found || res_err;
	assign res_sym  = done.found ? done.sym : '0;
	assign out_free = !m_valid_q || m_tready;

	// controller, accumulator and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			acc_q      <= '0;
			cnt_q      <= '0;
			start_q    <= 1'b0;
			m_valid_q  <= 1'b0;
			m_sym_q    <= '0;
			m_err_q    <= 1'b0;
			pend_sym_q <= '0;
			pend_err_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (kind)
							hufd_pkg::KIND_DECODE: begin
								acc_q   <= {acc_q[hufd_pkg::ACC_W-2:0], s_tdata[29]};
								cnt_q   <= cnt_q + hufd_pkg::CNT_W'(1);
								start_q <= 1'b1;
								state_q <= ST_SEARCH;
							end
							hufd_pkg::KIND_CLEAR: begin
								acc_q <= '0;
								cnt_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SEARCH: begin
					if (done.valid) begin
						pend_sym_q <= res_sym;
						pend_err_q <= res_err;
						if (!res_any) begin
							state_q <= ST_IDLE;
						end else begin
							acc_q <= '0;
							cnt_q <= '0;
							if (out_free) begin
								m_valid_q <= 1'b1;
								m_sym_q   <= res_sym;
								m_err_q   <= res_err;
								state_q   <= ST_IDLE;
							end else begin
								state_q <= ST_HOLD;
							end
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_sym_q   <= pend_sym_q;
						m_err_q   <= pend_err_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_sym_q;
	assign m_tuser  = m_err_q;

endmodule

// File: rtl/hufd_check.sv
`timescale 1ns / 1ps
// port-level checks for the bit-serial huffman decoder, bound to the top level
// depends on hufd_pkg and huffman_bit_serial_decoder

module hufd_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic [0:0]  m_tuser
);

	// a decode bit starts a search, so no word is taken next cycle
	a_decode_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == hufd_pkg::KIND_DECODE) |=> !s_tready)
		else $error("word accepted during a search");

	// the input stays ready in the cycle after a load or clear word
	a_load_clear_quick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready &&
		((s_tuser == hufd_pkg::KIND_LOAD) || (s_tuser == hufd_pkg::KIND_CLEAR))
		|=> s_tready)
		else $error("input stalled after a load or clear word");

	// an error result carries symbol zero
	a_err_sym_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == 8'd0))
		else $error("error result with nonzero symbol");

	// a fresh result only follows a search
	a_result_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a search");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind huffman_bit_serial_decoder hufd_check u_check (.*);

// File: test/huffman_bit_serial_decoder_tb.sv
`timescale 1ns / 1ps
// self-checking bench for huffman_bit_serial_decoder: directed words, then random code tables
// with messages encoded in them, checked against a bit-accurate decode predictor
// depends on hufd_pkg and the decoder rtl

module huffman_bit_serial_decoder_tb;
	import hufd_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int WORD_TARGET = 1100;
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = NUM_SYMBOLS + 16;
	localparam int STEADY_FROM = 350;
	localparam int STEADY_TO   = 600;

	// one input word as the bench sees it
	typedef struct {
		logic [1:0]        kind;
		logic [SYM_W-1:0]  sym;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
		logic              sbit;
		bit                hold;
	} stream_word_t;

	// one result word
	typedef struct {
		logic [SYM_W-1:0] sym;
		logic             err;
	} decode_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // entry_symbol, entry_length, entry_code, stream_bit, zero
	logic [1:0]  s_tuser = '0;   // kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // decoded_symbol
	logic [0:0]  m_tuser;        // overflow_error

	huffman_bit_serial_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// predictor state: table and accumulator
	logic [CODE_W-1:0] model_code [NUM_SYMBOLS];
	logic [LEN_W-1:0]  model_len  [NUM_SYMBOLS];
	logic [ACC_W-1:0]  model_acc;
	int                model_cnt;

	stream_word_t   pending [$];
	decode_result_t expected_results [$];
	stream_word_t   cur_word;

	// stimulus planning state
	logic [SYM_W-1:0]  live_syms [$];
	logic [SYM_W-1:0]  alpha_sym [$];
	logic [CODE_W-1:0] alpha_code [$];
	int                alpha_len [$];
	bit                hold_next;
	int                ignored_planned;
	int                phase_no;

	// run statistics
	int words_sent, n_loads, n_decodes, n_clears, n_ignored;
	int n_symbols, n_overflows, mismatches, quiet_cycles;
	bit steady;

	assign steady = (words_sent >= STEADY_FROM) && (words_sent < STEADY_TO);

	// clock and reset
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// decode predictor: applies one word, returns 1 when it yields a result
	function automatic bit decode_predict(input stream_word_t w, output decode_result_t r);
		bit hit;
		hit = 1'b0;
		r.sym = '0;
		r.err = 1'b0;
		case (w.kind)
			KIND_LOAD: begin
				model_code[w.sym] = w.code;
				model_len[w.sym]  = w.len;
			end
			KIND_CLEAR: begin
				model_acc = '0;
				model_cnt = 0;
			end
			KIND_DECODE: begin
				model_acc = {model_acc[ACC_W-2:0], w.sbit};
				model_cnt++;
				// lowest present symbol whose code and length match wins
				for (int s = 0; s < NUM_SYMBOLS; s++) begin
					if (!hit && model_len[s] != 0 && model_len[s] == model_cnt &&
					    model_len[s] <= MAX_CODE_LEN &&
					    (32'(model_code[s]) & ((32'd1 << model_len[s]) - 32'd1)) ==
					    32'(model_acc)) begin
						hit = 1'b1;
						r.sym = SYM_W'(s);
					end
				end
				// no longer code can match past the maximum length
				if (!hit && model_cnt >= MAX_CODE_LEN) begin
					hit = 1'b1;
					r.err = 1'b1;
				end
				if (hit) begin
					model_acc = '0;
					model_cnt = 0;
				end
			end
			default: ;
		endcase
		return hit;
	endfunction

	// stimulus helpers
	task automatic add_word(input logic [1:0] kind, input logic [SYM_W-1:0] sym,
			input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code, input logic sbit);
		stream_word_t w;
		w.kind = kind;
		w.sym  = sym;
		w.len  = len;
		w.code = code;
		w.sbit = sbit;
		w.hold = hold_next;
		hold_next = 1'b0;
		pending.push_back(w);
		if (kind == KIND_UNUSED) ignored_planned++;
	endtask

	task automatic add_load(input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
			input logic [CODE_W-1:0] code);
		add_word(KIND_LOAD, sym, len, code, 1'($urandom));
		live_syms.push_back(sym);
	endtask

	task automatic add_bit(input logic b);
		add_word(KIND_DECODE, SYM_W'($urandom), LEN_W'($urandom), CODE_W'($urandom), b);
	endtask

	task automatic add_clear();
		add_word(KIND_CLEAR, SYM_W'($urandom), LEN_W'($urandom), CODE_W'($urandom),
			1'($urandom));
	endtask

	// code bits from position hi down to lo, first bit first
	task automatic add_code_bits(input logic [CODE_W-1:0] code, input int hi, input int lo);
		for (int i = hi; i >= lo; i--) add_bit(code[i]);
	endtask

	// random prefix code built by splitting leaves, loaded into the table
	task automatic build_alphabet();
		logic [CODE_W-1:0] lc [$];
		int                ll [$];
		bit                used [NUM_SYMBOLS];
		int n, pick, depth_cap, l, s, k;
		bit chain;
		logic [CODE_W-1:0] c, mask;
		alpha_sym.delete();
		alpha_code.delete();
		alpha_len.delete();
		foreach (used[i]) used[i] = 1'b0;
		chain = ($urandom_range(0, 3) == 0);
		depth_cap = chain ? MAX_CODE_LEN : $urandom_range(3, 8);
		n = chain ? $urandom_range(12, 20) : $urandom_range(2, 12);
		lc = '{16'd0, 16'd1};
		ll = '{1, 1};
		repeat (n - 2) begin
			pick = ($urandom_range(0, 3) != 0 || !chain) && $urandom_range(0, 1) == 0 ?
				$urandom_range(0, lc.size() - 1) : lc.size() - 1;
			if (ll[pick] < depth_cap) begin
				c = lc[pick];
				l = ll[pick];
				lc.delete(pick);
				ll.delete(pick);
				lc.push_back({c[CODE_W-2:0], 1'b0});
				ll.push_back(l + 1);
				lc.push_back({c[CODE_W-2:0], 1'b1});
				ll.push_back(l + 1);
			end
		end
		// incomplete code: some bit strings then run into an overflow
		if ($urandom_range(0, 1) == 0) begin
			repeat ($urandom_range(1, 2)) begin
				if (lc.size() > 1) begin
					pick = $urandom_range(0, lc.size() - 1);
					lc.delete(pick);
					ll.delete(pick);
				end
			end
		end
		foreach (lc[i]) begin
			do s = $urandom_range(0, NUM_SYMBOLS - 1); while (used[s]);
			used[s] = 1'b1;
			mask = CODE_W'((32'd1 << ll[i]) - 32'd1);
			// bits above the length are noise
			add_load(SYM_W'(s), LEN_W'(ll[i]), (CODE_W'($urandom) & ~mask) | lc[i]);
			alpha_sym.push_back(SYM_W'(s));
			alpha_code.push_back(lc[i]);
			alpha_len.push_back(ll[i]);
		end
		// a second symbol sharing a code: the lower one must win
		if ($urandom_range(0, 3) == 0) begin
			k = $urandom_range(0, alpha_sym.size() - 1);
			do s = $urandom_range(0, NUM_SYMBOLS - 1); while (used[s]);
			used[s] = 1'b1;
			mask = CODE_W'((32'd1 << alpha_len[k]) - 32'd1);
			add_load(SYM_W'(s), LEN_W'(alpha_len[k]), (CODE_W'($urandom) & ~mask) | alpha_code[k]);
		end
		// length beyond the maximum never matches
		if ($urandom_range(0, 2) == 0) begin
			do s = $urandom_range(0, NUM_SYMBOLS - 1); while (used[s]);
			add_load(SYM_W'(s), LEN_W'($urandom_range(MAX_CODE_LEN + 1, 31)), CODE_W'($urandom));
		end
	endtask

	// one phase: usually retire the old table, load a new one, send a message through it
	task automatic run_phase();
		int k, cut, len;
		logic [CODE_W-1:0] code;
		if (phase_no % 5 == 0) hold_next = 1'b1;
		phase_no++;
		if ($urandom_range(0, 3) != 0) begin
			foreach (live_syms[i])
				add_word(KIND_LOAD, live_syms[i], '0, CODE_W'($urandom), 1'($urandom));
			live_syms.delete();
		end
		add_clear();
		build_alphabet();
		repeat ($urandom_range(4, 14)) begin
			k = $urandom_range(0, alpha_sym.size() - 1);
			code = alpha_code[k];
			len = alpha_len[k];
			case ($urandom_range(0, 19))
				0, 1: repeat ($urandom_range(1, 20)) add_bit(1'($urandom));
				2: begin
					// code cut short by a clear
					cut = $urandom_range(1, len);
					add_code_bits(code, len - 1, len - cut);
					add_clear();
				end
				3: add_word(KIND_UNUSED, SYM_W'($urandom), LEN_W'($urandom),
					CODE_W'($urandom), 1'($urandom));
				4: begin
					// table write in the middle of a code
					cut = $urandom_range(0, len - 1);
					add_code_bits(code, len - 1, len - cut);
					add_load(SYM_W'($urandom), LEN_W'($urandom_range(0, MAX_CODE_LEN)),
						CODE_W'($urandom));
					add_code_bits(code, len - 1 - cut, 0);
				end
				default: add_code_bits(code, len - 1, 0);
			endcase
		end
	endtask

	// input driver: holds a word until it is taken
	always @(posedge clk) begin
		decode_result_t r;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				words_sent++;
				case (cur_word.kind)
					KIND_LOAD:   n_loads++;
					KIND_DECODE: n_decodes++;
					KIND_CLEAR:  n_clears++;
					default:     n_ignored++;
				endcase
				if (decode_predict(cur_word, r)) expected_results.push_back(r);
			end
			if (!s_tvalid || s_tready) begin
				if (pending.size() != 0 && (steady || $urandom_range(0, 99) >= 14) &&
				    !(pending[0].hold && expected_results.size() != 0)) begin
					cur_word = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= cur_word.kind;
					s_tdata  <= {2'b00, cur_word.sbit, cur_word.code, cur_word.len, cur_word.sym};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output monitor and checker
	always @(posedge clk) begin
		decode_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (m_tuser[0]) n_overflows++;
				else n_symbols++;
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word, expected none, got symbol %0d error %0b",
						$time, m_tdata, m_tuser[0]);
				end else begin
					want = expected_results.pop_front();
					if (m_tdata !== want.sym) begin
						mismatches++;
						$display("%0t: decoded_symbol expected %0d, got %0d",
							$time, want.sym, m_tdata);
					end
					if (m_tuser[0] !== want.err) begin
						mismatches++;
						$display("%0t: overflow_error expected %0b, got %0b",
							$time, want.err, m_tuser[0]);
					end
				end
			end
			m_tready <= steady || $urandom_range(0, 99) >= 14;
		end
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("huffman_bit_serial_decoder_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus plan and end of run
	initial begin
		foreach (model_len[i]) begin
			model_len[i]  = '0;
			model_code[i] = '0;
		end
		model_acc = '0;
		model_cnt = 0;

		// directed: ignored kind, tie on a one-bit code, long and overlong lengths
		add_word(KIND_UNUSED, '1, '1, '1, 1'b1);
		add_load(8'd0, 5'd1, 16'hFFFE);
		add_load(8'd255, 5'd1, 16'h0000);
		add_bit(1'b0);
		add_load(8'd7, 5'd17, 16'h0001);
		add_word(KIND_LOAD, 8'd0, 5'd0, 16'h1234, 1'b0);
		add_word(KIND_LOAD, 8'd255, 5'd0, 16'hFFFF, 1'b1);
		add_load(8'd200, 5'd16, 16'hA5C3);
		add_bit(1'b1);
		add_clear();
		add_code_bits(16'hA5C3, MAX_CODE_LEN - 1, 0);

		while (pending.size() - ignored_planned < WORD_TARGET) run_phase();

		while (pending.size() != 0 || s_tvalid) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d words: %0d table loads, %0d stream bits, %0d clears, %0d ignored",
			words_sent, n_loads, n_decodes, n_clears, n_ignored);
		$display("results seen: %0d symbols, %0d overflows", n_symbols, n_overflows);
		if (mismatches == 0) begin
			$display("huffman_bit_serial_decoder_tb: done, clean");
		end else begin
			$display("huffman_bit_serial_decoder_tb: done, errors");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/hufd_pkg.sv
rtl/hufd_cell.sv
rtl/hufd_chain.sv
rtl/huffman_bit_serial_decoder.sv
rtl/hufd_check.sv
test/huffman_bit_serial_decoder_tb.sv
